[rtl/jns_pkg.sv]
// Package for the JSON number scanner: syntax flag positions, character codes,
// digit-pattern constants and the result beat type.
// No dependencies.
package jns_pkg;

  localparam int FLAG_BITS = 7;

  localparam int F_BSIGN = 0;
  localparam int F_BDIG  = 1;
  localparam int F_DOT   = 2;
  localparam int F_FDIG  = 3;
  localparam int F_EMARK = 4;
  localparam int F_ESIGN = 5;
  localparam int F_EDIG  = 6;

  localparam logic [FLAG_BITS-1:0] PART_MASK     = 7'h5E;
  localparam logic [FLAG_BITS-1:0] PAT_EXP_FIRST = 7'h1E;
  localparam logic [FLAG_BITS-1:0] PAT_EXP_NODOT = 7'h12;
  localparam logic [FLAG_BITS-1:0] PAT_EXP_MORE  = 7'h5E;
  localparam logic [FLAG_BITS-1:0] PAT_EXP_MORE2 = 7'h52;
  localparam logic [FLAG_BITS-1:0] PAT_FRAC_1ST  = 7'h06;
  localparam logic [FLAG_BITS-1:0] PAT_FRAC_MORE = 7'h0E;
  localparam logic [FLAG_BITS-1:0] PAT_INT_1ST   = 7'h00;
  localparam logic [FLAG_BITS-1:0] PAT_INT_MORE  = 7'h02;

  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam int OUT_COUNT_BITS = 16;

  typedef struct packed {
    logic [OUT_COUNT_BITS-1:0] base_digits;
    logic [OUT_COUNT_BITS-1:0] fraction_digits;
    logic [OUT_COUNT_BITS-1:0] exponent_digits;
    logic                      base_sign_seen;
    logic                      has_fraction;
    logic                      has_exponent;
    logic                      exponent_sign_seen;
    logic                      syntax_error;
  } result_t;

endpackage

[rtl/jns_if.sv]
// Channel interfaces for the JSON number scanner: character beats in and
// result beats out, each with valid/ready. No dependencies.
interface jns_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;

  modport source (output valid, output character, input ready);
  modport sink   (input valid, input character, output ready);
endinterface

interface jns_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] base_digits;
  logic [15:0] fraction_digits;
  logic [15:0] exponent_digits;
  logic        base_sign_seen;
  logic        has_fraction;
  logic        has_exponent;
  logic        exponent_sign_seen;
  logic        syntax_error;

  modport source (output valid, output base_digits, output fraction_digits,
                  output exponent_digits, output base_sign_seen, output has_fraction,
                  output has_exponent, output exponent_sign_seen, output syntax_error,
                  input ready);
  modport sink   (input valid, input base_digits, input fraction_digits,
                  input exponent_digits, input base_sign_seen, input has_fraction,
                  input has_exponent, input exponent_sign_seen, input syntax_error,
                  output ready);
endinterface

[rtl/jns_step.sv]
// Per-character update of the scanner state and result formation on a terminator.
// Purely combinational. Depends on jns_pkg.
module jns_step
  import jns_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic [7:0]            character,
  input  logic [FLAG_BITS-1:0]  flags,
  input  logic [COUNT_BITS-1:0] int_cnt,
  input  logic [COUNT_BITS-1:0] frac_cnt,
  input  logic [COUNT_BITS-1:0] exp_cnt,
  input  logic                  err,
  output logic [FLAG_BITS-1:0]  flags_next,
  output logic [COUNT_BITS-1:0] int_cnt_next,
  output logic [COUNT_BITS-1:0] frac_cnt_next,
  output logic [COUNT_BITS-1:0] exp_cnt_next,
  output logic                  err_next,
  output logic                  emit,
  output result_t               result
);

  logic [COUNT_BITS-1:0] int_bump;
  logic [COUNT_BITS-1:0] frac_bump;
  logic [COUNT_BITS-1:0] exp_bump;
  logic [OUT_COUNT_BITS-1:0] int_out;
  logic [OUT_COUNT_BITS-1:0] frac_out;
  logic [OUT_COUNT_BITS-1:0] exp_out;
  logic is_digit;
  logic end_err;

  assign int_bump  = (&int_cnt)  ? int_cnt  : int_cnt  + COUNT_BITS'(1);
  assign frac_bump = (&frac_cnt) ? frac_cnt : frac_cnt + COUNT_BITS'(1);
  assign exp_bump  = (&exp_cnt)  ? exp_cnt  : exp_cnt  + COUNT_BITS'(1);

  if (COUNT_BITS > OUT_COUNT_BITS) begin : g_clamp
    assign int_out  = (|int_cnt[COUNT_BITS-1:OUT_COUNT_BITS])  ? '1 :
                      int_cnt[OUT_COUNT_BITS-1:0];
    assign frac_out = (|frac_cnt[COUNT_BITS-1:OUT_COUNT_BITS]) ? '1 :
                      frac_cnt[OUT_COUNT_BITS-1:0];
    assign exp_out  = (|exp_cnt[COUNT_BITS-1:OUT_COUNT_BITS])  ? '1 :
                      exp_cnt[OUT_COUNT_BITS-1:0];
  end else begin : g_extend
    assign int_out  = OUT_COUNT_BITS'(int_cnt);
    assign frac_out = OUT_COUNT_BITS'(frac_cnt);
    assign exp_out  = OUT_COUNT_BITS'(exp_cnt);
  end

  assign emit     = (character == CH_COMMA) || (character == CH_RBRACK) ||
                    (character == CH_RBRACE);
  assign is_digit = (character >= CH_ZERO) && (character <= CH_NINE);
  assign end_err  = !flags[F_BDIG] || (flags[F_DOT] && !flags[F_FDIG]) ||
                    (flags[F_EMARK] && !flags[F_EDIG]);

  always_comb begin
    result.base_digits        = int_out;
    result.fraction_digits    = frac_out;
    result.exponent_digits    = exp_out;
    result.base_sign_seen     = flags[F_BSIGN];
    result.has_fraction       = flags[F_DOT];
    result.has_exponent       = flags[F_EMARK];
    result.exponent_sign_seen = flags[F_ESIGN];
    result.syntax_error       = err || end_err;
  end

  always_comb begin
    flags_next    = flags;
    int_cnt_next  = int_cnt;
    frac_cnt_next = frac_cnt;
    exp_cnt_next  = exp_cnt;
    err_next      = err;
    if (emit) begin
      flags_next    = '0;
      int_cnt_next  = '0;
      frac_cnt_next = '0;
      exp_cnt_next  = '0;
      err_next      = 1'b0;
    end else if ((character == CH_PLUS) || (character == CH_MINUS)) begin
      if (!flags[F_BDIG]) begin
        if (flags[F_BSIGN]) begin
          err_next = 1'b1;
        end
        flags_next[F_BSIGN] = 1'b1;
      end else begin
        if (!flags[F_EMARK] || flags[F_EDIG] || flags[F_ESIGN]) begin
          err_next = 1'b1;
        end
        flags_next[F_ESIGN] = 1'b1;
      end
    end else if (character == CH_DOT) begin
      if (!flags[F_BDIG] || flags[F_DOT] || flags[F_EMARK]) begin
        err_next = 1'b1;
      end
      flags_next[F_DOT] = 1'b1;
    end else if ((character == CH_LOW_E) || (character == CH_UP_E)) begin
      if (flags[F_EMARK] || !(flags[F_FDIG] || (flags[F_BDIG] != flags[F_DOT]))) begin
        err_next = 1'b1;
      end
      flags_next[F_EMARK] = 1'b1;
    end else if (is_digit) begin
      case (flags & PART_MASK)
        PAT_EXP_FIRST, PAT_EXP_NODOT: begin
          flags_next[F_EDIG] = 1'b1;
          exp_cnt_next       = exp_bump;
        end
        PAT_EXP_MORE, PAT_EXP_MORE2: begin
          exp_cnt_next = exp_bump;
        end
        PAT_FRAC_1ST: begin
          flags_next[F_FDIG] = 1'b1;
          frac_cnt_next      = frac_bump;
        end
        PAT_FRAC_MORE: begin
          frac_cnt_next = frac_bump;
        end
        PAT_INT_1ST: begin
          flags_next[F_BDIG] = 1'b1;
          int_cnt_next       = int_bump;
        end
        PAT_INT_MORE: begin
          int_cnt_next = int_bump;
        end
        default: begin
          err_next = 1'b1;
        end
      endcase
    end else begin
      err_next = 1'b1;
    end
  end

endmodule

[rtl/json_number_scanner_core.sv]
// Top level of the JSON number scanner: state registers, result register and
// handshake. Depends on jns_pkg, jns_if (jns_char_if, jns_result_if) and jns_step.
//
// Usage: the text of a JSON number arrives one byte per beat on the chars
// channel. Each byte updates seven syntax flags, three saturating digit
// counters of COUNT_BITS bits and a sticky error flag. A comma, ']' or '}'
// ends the number: it produces one beat on the numbers channel with the
// digit counts (clamped to 16 bits), four flags and the error flag, and clears
// the state for the next number. All other bytes produce no beat.
// A result beat is registered and is valid the cycle after its terminator is accepted.
// Throughput: one byte per cycle unless a result beat stalls; the flag update
// is short combinational logic between the state and result registers.
// Reset (synchronous, active high) clears the state and drops the result valid.
// Stall: the result register holds while the receiver is not ready; bytes keep
// being accepted as long as the result register is empty or being drained,
// so a result beat that waits on a stalled receiver holds back every byte
// until it is taken.
module json_number_scanner_core
  import jns_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input logic         clk,
  input logic         rst,
  jns_char_if.sink    chars,
  jns_result_if.source numbers
);

  logic [FLAG_BITS-1:0]  flags;
  logic [COUNT_BITS-1:0] int_cnt;
  logic [COUNT_BITS-1:0] frac_cnt;
  logic [COUNT_BITS-1:0] exp_cnt;
  logic                  err;
  logic [FLAG_BITS-1:0]  flags_next;
  logic [COUNT_BITS-1:0] int_cnt_next;
  logic [COUNT_BITS-1:0] frac_cnt_next;
  logic [COUNT_BITS-1:0] exp_cnt_next;
  logic                  err_next;
  logic                  emit;
  result_t               step_result;
  result_t               result;
  logic                  result_valid;
  logic                  accept;

  jns_step #(
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .character    (chars.character),
    .flags        (flags),
    .int_cnt      (int_cnt),
    .frac_cnt     (frac_cnt),
    .exp_cnt      (exp_cnt),
    .err          (err),
    .flags_next   (flags_next),
    .int_cnt_next (int_cnt_next),
    .frac_cnt_next(frac_cnt_next),
    .exp_cnt_next (exp_cnt_next),
    .err_next     (err_next),
    .emit         (emit),
    .result       (step_result)
  );

  assign chars.ready = !result_valid || numbers.ready;
  assign accept      = chars.valid && chars.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      flags    <= '0;
      int_cnt  <= '0;
      frac_cnt <= '0;
      exp_cnt  <= '0;
      err      <= 1'b0;
    end else if (accept) begin
      flags    <= flags_next;
      int_cnt  <= int_cnt_next;
      frac_cnt <= frac_cnt_next;
      exp_cnt  <= exp_cnt_next;
      err      <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && emit) begin
      result_valid <= 1'b1;
    end else if (numbers.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      result <= step_result;
    end
  end

  assign numbers.valid              = result_valid;
  assign numbers.base_digits        = result.base_digits;
  assign numbers.fraction_digits    = result.fraction_digits;
  assign numbers.exponent_digits    = result.exponent_digits;
  assign numbers.base_sign_seen     = result.base_sign_seen;
  assign numbers.has_fraction       = result.has_fraction;
  assign numbers.has_exponent       = result.has_exponent;
  assign numbers.exponent_sign_seen = result.exponent_sign_seen;
  assign numbers.syntax_error       = result.syntax_error;

`ifndef SYNTHESIS
  a_term_gives_beat: assert property (@(posedge clk) disable iff (rst)
    (accept && emit) |=> numbers.valid)
    else $error("terminator accepted without a result beat");

  a_term_clears_state: assert property (@(posedge clk) disable iff (rst)
    (accept && emit) |=> (flags == '0 && int_cnt == '0 && frac_cnt == '0 &&
                          exp_cnt == '0 && !err))
    else $error("state not cleared after terminator");

  a_no_base_digit_is_error: assert property (@(posedge clk) disable iff (rst)
    numbers.valid |-> (numbers.base_digits != '0 || numbers.syntax_error))
    else $error("number without integer digits reported as valid");

  a_stall_keeps_beat: assert property (@(posedge clk) disable iff (rst)
    (numbers.valid && !numbers.ready) |=> (numbers.valid && $stable(result)))
    else $error("stalled result beat lost or changed");
`endif

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for json_number_scanner_core: streams number text in byte beats
// and compares each result beat with a scanner model kept in the bench.
// Depends on jns_pkg, jns_if and the core.
module tb;
  import jns_pkg::*;

  localparam int COUNT_BITS = 16;
  localparam int STALL_LIMIT = 5000;
  localparam int LONG_RUN = 24;

  typedef struct {
    logic [7:0]  character;
    int unsigned wait_cycles;
    bit          drain_first;
  } char_beat_t;

  logic clk;
  logic rst;

  jns_char_if   chars_if ();
  jns_result_if numbers_if ();

  json_number_scanner_core #(.COUNT_BITS(COUNT_BITS)) dut (
    .clk(clk),
    .rst(rst),
    .chars(chars_if),
    .numbers(numbers_if)
  );

  char_beat_t pending_chars[$];
  result_t expected_numbers[$];
  logic [7:0] number_text[$];

  logic [FLAG_BITS-1:0]  scan_flags;
  logic [COUNT_BITS-1:0] scan_int_count;
  logic [COUNT_BITS-1:0] scan_frac_count;
  logic [COUNT_BITS-1:0] scan_exp_count;
  logic                  scan_error;

  int error_count;
  int send_calm;
  int recv_calm;
  bit steady;
  int send_idle_left;
  bit send_gap_loaded;
  int recv_stall_left;
  int idle_cycles;

  initial begin
    clk = 1'b0;
  end

  always #4 clk = ~clk;

  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  function automatic logic [COUNT_BITS-1:0] bump_count(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + COUNT_BITS'(1);
  endfunction

  function automatic logic [OUT_COUNT_BITS-1:0] clamp_count(input logic [COUNT_BITS-1:0] v);
    longint unsigned wide;
    wide = v;
    return (wide > 64'hFFFF) ? 16'hFFFF : 16'(wide);
  endfunction

  function automatic logic [7:0] pick_syntax();
    case ($urandom_range(0, 5))
      0: return CH_PLUS;
      1: return CH_MINUS;
      2: return CH_DOT;
      3: return CH_LOW_E;
      4: return CH_UP_E;
      default: return 8'(CH_ZERO + $urandom_range(0, 9));
    endcase
  endfunction

  function automatic logic [7:0] pick_terminator();
    case ($urandom_range(0, 2))
      0: return CH_COMMA;
      1: return CH_RBRACK;
      default: return CH_RBRACE;
    endcase
  endfunction

  task automatic scan_char(input logic [7:0] ch);
    logic [FLAG_BITS-1:0] f;
    logic err;
    logic b;
    logic d;
    result_t r;
    f = scan_flags;
    err = scan_error;
    if (ch == CH_COMMA || ch == CH_RBRACK || ch == CH_RBRACE) begin
      if (!f[F_BDIG]) err = 1'b1;
      if (f[F_DOT] && !f[F_FDIG]) err = 1'b1;
      if (f[F_EMARK] && !f[F_EDIG]) err = 1'b1;
      r.base_digits = clamp_count(scan_int_count);
      r.fraction_digits = clamp_count(scan_frac_count);
      r.exponent_digits = clamp_count(scan_exp_count);
      r.base_sign_seen = f[F_BSIGN];
      r.has_fraction = f[F_DOT];
      r.has_exponent = f[F_EMARK];
      r.exponent_sign_seen = f[F_ESIGN];
      r.syntax_error = err;
      expected_numbers.push_back(r);
      f = '0;
      err = 1'b0;
      scan_int_count = '0;
      scan_frac_count = '0;
      scan_exp_count = '0;
    end else if (ch == CH_PLUS || ch == CH_MINUS) begin
      if (!f[F_BDIG]) begin
        if (f[F_BSIGN]) err = 1'b1;
        f[F_BSIGN] = 1'b1;
      end else begin
        if (!f[F_EMARK] || f[F_EDIG] || f[F_ESIGN]) err = 1'b1;
        f[F_ESIGN] = 1'b1;
      end
    end else if (ch == CH_DOT) begin
      if (!f[F_BDIG] || f[F_DOT] || f[F_EMARK]) err = 1'b1;
      f[F_DOT] = 1'b1;
    end else if (ch == CH_LOW_E || ch == CH_UP_E) begin
      b = f[F_BDIG];
      d = f[F_DOT];
      if (f[F_EMARK]) err = 1'b1;
      if (!(f[F_FDIG] || (b != d))) err = 1'b1;
      f[F_EMARK] = 1'b1;
    end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
      case (f & PART_MASK)
        PAT_EXP_FIRST, PAT_EXP_NODOT: begin
          f[F_EDIG] = 1'b1;
          scan_exp_count = bump_count(scan_exp_count);
        end
        PAT_EXP_MORE, PAT_EXP_MORE2: begin
          scan_exp_count = bump_count(scan_exp_count);
        end
        PAT_FRAC_1ST: begin
          f[F_FDIG] = 1'b1;
          scan_frac_count = bump_count(scan_frac_count);
        end
        PAT_FRAC_MORE: begin
          scan_frac_count = bump_count(scan_frac_count);
        end
        PAT_INT_1ST: begin
          f[F_BDIG] = 1'b1;
          scan_int_count = bump_count(scan_int_count);
        end
        PAT_INT_MORE: begin
          scan_int_count = bump_count(scan_int_count);
        end
        default: err = 1'b1;
      endcase
    end else begin
      err = 1'b1;
    end
    scan_flags = f;
    scan_error = err;
  endtask

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    error_count++;
    if (error_count <= 200) begin
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    end
  endtask

  task automatic check_field(input string what, input longint unsigned got,
                             input longint unsigned want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  task automatic queue_char(input logic [7:0] ch, input bit drain);
    char_beat_t beat;
    beat.character = ch;
    beat.wait_cycles = steady ? 0 : draw_wait(send_calm);
    beat.drain_first = drain;
    pending_chars.push_back(beat);
  endtask

  task automatic queue_text(input string s, input bit drain);
    for (int i = 0; i < s.len(); i++) begin
      queue_char(s[i], drain && i == 0);
    end
  endtask

  task automatic add_digits(input int n);
    for (int i = 0; i < n; i++) begin
      number_text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    end
  endtask

  task automatic flush_number(input bit drain);
    foreach (number_text[i]) begin
      queue_char(number_text[i], drain && i == 0);
    end
    number_text.delete();
  endtask

  initial begin
    int random_count;
    int kind;
    int n;
    int pos;
    rst = 1'b1;
    chars_if.valid = 1'b0;
    chars_if.character = '0;
    numbers_if.ready = 1'b0;
    error_count = 0;
    send_calm = 0;
    recv_calm = 0;
    steady = 1'b0;
    scan_flags = '0;
    scan_int_count = '0;
    scan_frac_count = '0;
    scan_exp_count = '0;
    scan_error = 1'b0;

    queue_text("0,", 1'b0);
    queue_text("-12.5e+3]", 1'b0);
    queue_text("+1E-9}", 1'b0);
    queue_text("0.5E3,", 1'b1);
    queue_text("--1,1.,.5,", 1'b0);
    queue_text("1.2.3e1e2]", 1'b0);
    queue_text("1e+-2+,1-2,1.e5,1e5.}", 1'b0);
    queue_text("e7],", 1'b0);
    queue_char(8'h00, 1'b0);
    queue_char(8'hFF, 1'b0);
    queue_char(CH_COMMA, 1'b0);

    steady = 1'b1;
    add_digits(LONG_RUN);
    number_text.push_back(CH_DOT);
    add_digits(LONG_RUN);
    number_text.push_back(CH_UP_E);
    add_digits(LONG_RUN);
    number_text.push_back(CH_RBRACE);
    flush_number(1'b1);
    steady = 1'b0;

    random_count = 0;
    while (random_count < 1800) begin
      kind = $urandom_range(0, 9);
      if (kind < 9) begin
        if ($urandom_range(0, 2) == 0) begin
          number_text.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
        end
        add_digits(($urandom_range(0, 15) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 5));
        if ($urandom_range(0, 4) < 2) begin
          number_text.push_back(CH_DOT);
          add_digits($urandom_range(1, 4));
        end
        if ($urandom_range(0, 9) < 3) begin
          number_text.push_back($urandom_range(0, 1) ? CH_LOW_E : CH_UP_E);
          if ($urandom_range(0, 1)) begin
            number_text.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
          end
          add_digits($urandom_range(1, 3));
        end
        if (kind >= 7) begin
          pos = $urandom_range(0, number_text.size());
          case ($urandom_range(0, 2))
            0: number_text.insert(pos, pick_syntax());
            1: if (pos < number_text.size()) number_text.delete(pos);
            default: number_text.insert(pos, 8'($urandom_range(0, 255)));
          endcase
        end
        number_text.push_back(pick_terminator());
      end else begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          number_text.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                                     : pick_syntax());
        end
        if ($urandom_range(0, 4) != 0) number_text.push_back(pick_terminator());
      end
      random_count += number_text.size();
      flush_number($urandom_range(0, 39) == 0);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (pending_chars.size() != 0 || expected_numbers.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (expected_numbers.size() != 0) begin
      report_mismatch("results still expected", 0, expected_numbers.size());
    end
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      chars_if.valid <= 1'b0;
      send_gap_loaded = 1'b0;
      send_idle_left = 0;
    end else begin
      if (chars_if.valid && chars_if.ready) begin
        scan_char(chars_if.character);
        void'(pending_chars.pop_front());
        send_gap_loaded = 1'b0;
      end
      if (!(chars_if.valid && !chars_if.ready)) begin
        if (pending_chars.size() == 0) begin
          chars_if.valid <= 1'b0;
        end else begin
          if (!send_gap_loaded) begin
            send_idle_left = pending_chars[0].wait_cycles;
            send_gap_loaded = 1'b1;
          end
          if (pending_chars[0].drain_first && expected_numbers.size() != 0) begin
            chars_if.valid <= 1'b0;
          end else if (send_idle_left > 0) begin
            send_idle_left--;
            chars_if.valid <= 1'b0;
          end else begin
            chars_if.valid <= 1'b1;
            chars_if.character <= pending_chars[0].character;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      numbers_if.ready <= 1'b0;
      recv_stall_left = draw_wait(recv_calm);
    end else begin
      if (numbers_if.valid && numbers_if.ready) begin
        if (expected_numbers.size() == 0) begin
          report_mismatch("result beat with nothing expected", 1, 0);
        end else begin
          want = expected_numbers.pop_front();
          check_field("base_digits", numbers_if.base_digits, want.base_digits);
          check_field("fraction_digits", numbers_if.fraction_digits, want.fraction_digits);
          check_field("exponent_digits", numbers_if.exponent_digits, want.exponent_digits);
          check_field("base_sign_seen", numbers_if.base_sign_seen, want.base_sign_seen);
          check_field("has_fraction", numbers_if.has_fraction, want.has_fraction);
          check_field("has_exponent", numbers_if.has_exponent, want.has_exponent);
          check_field("exponent_sign_seen", numbers_if.exponent_sign_seen,
                      want.exponent_sign_seen);
          check_field("syntax_error", numbers_if.syntax_error, want.syntax_error);
        end
        recv_stall_left = draw_wait(recv_calm);
      end
      if (recv_stall_left > 0) begin
        recv_stall_left--;
        numbers_if.ready <= 1'b0;
      end else begin
        numbers_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else if ((chars_if.valid && chars_if.ready) ||
                 (numbers_if.valid && numbers_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

endmodule

[json_number_scanner_core.f]
rtl/jns_pkg.sv
rtl/jns_if.sv
rtl/jns_step.sv
rtl/json_number_scanner_core.sv
bench/tb.sv
